FILE: design/cdml_pkg.sv
// ----------------------------------------------------------------------------
// cdml_pkg
// Shared constants, register map and decode helpers for the command driven
// motor and LED PWM generator.
// ----------------------------------------------------------------------------
package cdml_pkg;

    // Number of LED channels that can light; the pin vector is always 3 wide
    localparam int LED_CHANNELS = 3;
    localparam int LED_PINS     = 3;

    // Channels at or above LED_CHANNELS never light
    localparam logic [LED_PINS-1:0] LED_CH_MASK =
        LED_PINS'((1 << LED_CHANNELS) - 1);

    // Field widths
    localparam int CNT_W   = 8;
    localparam int DUTY_W  = 4;
    localparam int NIB_W   = 4;
    localparam int CFG_IDX_W = 3;

    // Configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MOTOR_PERIOD = 3'd0,
        REG_LED_PERIOD   = 3'd1,
        REG_LED1_END     = 3'd2,
        REG_LED2_START   = 3'd3,
        REG_LED2_END     = 3'd4,
        REG_LED3_START   = 3'd5,
        REG_LED3_END     = 3'd6
    } cfg_reg_t;

    // Register reset values
    localparam logic [CNT_W-1:0] RST_MOTOR_PERIOD = 8'd10;
    localparam logic [CNT_W-1:0] RST_LED_PERIOD   = 8'd12;
    localparam logic [CNT_W-1:0] RST_LED1_END     = 8'd4;
    localparam logic [CNT_W-1:0] RST_LED2_START   = 8'd4;
    localparam logic [CNT_W-1:0] RST_LED2_END     = 8'd8;
    localparam logic [CNT_W-1:0] RST_LED3_START   = 8'd8;
    localparam logic [CNT_W-1:0] RST_LED3_END     = 8'd12;

    // Command decode
    localparam logic [NIB_W-1:0]    MOTOR_OFF       = 4'd0;
    localparam logic [NIB_W-1:0]    MOTOR_LEVEL_MAX = 4'd5;
    localparam logic [DUTY_W-1:0]   DUTY_OFFSET     = 4'd5;
    localparam logic [LED_PINS-1:0] LED_ENABLE_RST  = 3'b111;

    // LED enable patterns
    typedef enum logic [NIB_W-1:0] {
        PAT_LED12  = 4'd0,
        PAT_LED13  = 4'd1,
        PAT_LED3   = 4'd2,
        PAT_LED2   = 4'd3,
        PAT_LED23  = 4'd4
    } led_pat_t;

    // Pattern code to LED enable bits; valid is low for unknown codes
    function automatic logic [LED_PINS:0] led_pattern(input logic [NIB_W-1:0] code);
        logic [LED_PINS:0] res;
        case (code)
            PAT_LED12: res = {1'b1, 3'b011};
            PAT_LED13: res = {1'b1, 3'b101};
            PAT_LED3:  res = {1'b1, 3'b100};
            PAT_LED2:  res = {1'b1, 3'b010};
            PAT_LED23: res = {1'b1, 3'b110};
            default:   res = '0;
        endcase
        return res;
    endfunction

    // Counter advance: wrap to zero when the next value reaches the period
    function automatic logic [CNT_W-1:0] advance(input logic [CNT_W-1:0] count,
                                                 input logic [CNT_W-1:0] period);
        logic [CNT_W:0] nxt;
        nxt = {1'b0, count} + {{CNT_W{1'b0}}, 1'b1};
        return (nxt >= {1'b0, period}) ? '0 : nxt[CNT_W-1:0];
    endfunction

endpackage

FILE: design/command_driven_motor_led_pwm.sv
// ----------------------------------------------------------------------------
// command_driven_motor_led_pwm
// One PWM tick per request: optional command decode, motor and LED pin
// levels, counter advance.
// ----------------------------------------------------------------------------
// Takes one tick request per clock and returns one result per request. A
// request is captured in an input register, decoded and evaluated against the
// motor and LED counters in combinational logic, and the pin levels land in
// the result register: throughput is one request per cycle as long as the
// result side keeps taking results. Configuration registers are written
// through the cfg port, which is always ready; index 7 is ignored.
module command_driven_motor_led_pwm (
    input  logic                                aclk,
    input  logic                                aresetn,
    // tick requests
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_command_present,
    input  logic [7:0]                          s_command_byte,
    // results
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_motor_out,
    output logic [cdml_pkg::LED_PINS-1:0]       m_led_drive_n,
    output logic                                m_power_pin,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cdml_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cdml_pkg::CNT_W-1:0]          cfg_data
);

    localparam int CW = cdml_pkg::CNT_W;
    localparam int NW = cdml_pkg::NIB_W;
    localparam int LP = cdml_pkg::LED_PINS;

    // Configuration registers
    logic [CW-1:0] motor_period_reg, led_period_reg;
    logic [CW-1:0] led1_end_reg, led2_start_reg, led2_end_reg;
    logic [CW-1:0] led3_start_reg, led3_end_reg;

    // PWM state
    logic [CW-1:0]                motor_count_reg, motor_count_next;
    logic [cdml_pkg::DUTY_W-1:0]  motor_duty_reg, motor_duty_next;
    logic                         motor_enable_reg, motor_enable_next;
    logic                         power_level_reg, power_level_next;
    logic [CW-1:0]                led_count_reg, led_count_next;
    logic [LP-1:0]                led_enable_reg, led_enable_next;

    // Input register
    logic          in_valid_reg;
    logic          in_present_reg;
    logic [7:0]    in_byte_reg;

    // Result register
    logic          out_valid_reg;
    logic          out_motor_reg, out_motor_next;
    logic [LP-1:0] out_led_n_reg, out_led_n_next;
    logic          out_power_reg;

    logic out_free, advance_en, in_accept;

    assign out_free   = !out_valid_reg || m_ready;
    assign advance_en = in_valid_reg && out_free;
    assign s_ready    = !in_valid_reg || out_free;
    assign in_accept  = s_valid && s_ready;
    assign cfg_ready  = 1'b1;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            motor_period_reg <= cdml_pkg::RST_MOTOR_PERIOD;
            led_period_reg   <= cdml_pkg::RST_LED_PERIOD;
            led1_end_reg     <= cdml_pkg::RST_LED1_END;
            led2_start_reg   <= cdml_pkg::RST_LED2_START;
            led2_end_reg     <= cdml_pkg::RST_LED2_END;
            led3_start_reg   <= cdml_pkg::RST_LED3_START;
            led3_end_reg     <= cdml_pkg::RST_LED3_END;
        end else if (cfg_valid && cfg_ready) begin
            case (cdml_pkg::cfg_reg_t'(cfg_index))
                cdml_pkg::REG_MOTOR_PERIOD: motor_period_reg <= cfg_data;
                cdml_pkg::REG_LED_PERIOD:   led_period_reg   <= cfg_data;
                cdml_pkg::REG_LED1_END:     led1_end_reg     <= cfg_data;
                cdml_pkg::REG_LED2_START:   led2_start_reg   <= cfg_data;
                cdml_pkg::REG_LED2_END:     led2_end_reg     <= cfg_data;
                cdml_pkg::REG_LED3_START:   led3_start_reg   <= cfg_data;
                cdml_pkg::REG_LED3_END:     led3_end_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Command decode, pin levels and counter advance
    always_comb begin
        logic [NW-1:0]   lo, hi;
        logic [LP:0]     pat;
        logic [CW-1:0]   mcount;
        logic [LP-1:0]   lit;

        lo  = in_byte_reg[NW-1:0];
        hi  = in_byte_reg[7:NW];
        pat = cdml_pkg::led_pattern(hi);

        motor_enable_next = motor_enable_reg;
        motor_duty_next   = motor_duty_reg;
        power_level_next  = power_level_reg;
        led_enable_next   = led_enable_reg;
        mcount            = motor_count_reg;

        if (in_present_reg) begin
            if (lo == cdml_pkg::MOTOR_OFF) begin
                motor_enable_next = 1'b0;
                motor_duty_next   = '0;
                mcount            = '0;
                power_level_next  = 1'b0;
            end else if (lo <= cdml_pkg::MOTOR_LEVEL_MAX) begin
                motor_enable_next = 1'b1;
                motor_duty_next   = lo + cdml_pkg::DUTY_OFFSET;
                mcount            = '0;
                power_level_next  = 1'b1;
            end
            if (pat[LP]) begin
                led_enable_next = pat[LP-1:0];
            end
        end

        out_motor_next   = motor_enable_next &&
                           (mcount < {{(CW-cdml_pkg::DUTY_W){1'b0}}, motor_duty_next});
        motor_count_next = cdml_pkg::advance(mcount, motor_period_reg);

        // LED windows over the shared counter
        lit[0] = led_count_reg < led1_end_reg;
        lit[1] = (led_count_reg >= led2_start_reg) && (led_count_reg < led2_end_reg);
        lit[2] = (led_count_reg >= led3_start_reg) && (led_count_reg < led3_end_reg);
        out_led_n_next = ~(lit & led_enable_next & cdml_pkg::LED_CH_MASK);
        led_count_next = cdml_pkg::advance(led_count_reg, led_period_reg);
    end

    // Control and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            motor_count_reg  <= '0;
            motor_duty_reg   <= '0;
            motor_enable_reg <= 1'b0;
            power_level_reg  <= 1'b0;
            led_count_reg    <= '0;
            led_enable_reg   <= cdml_pkg::LED_ENABLE_RST;
        end else begin
            if (in_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance_en) begin
                in_valid_reg <= 1'b0;
            end

            if (advance_en) begin
                out_valid_reg    <= 1'b1;
                motor_count_reg  <= motor_count_next;
                motor_duty_reg   <= motor_duty_next;
                motor_enable_reg <= motor_enable_next;
                power_level_reg  <= power_level_next;
                led_count_reg    <= led_count_next;
                led_enable_reg   <= led_enable_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            in_present_reg <= s_command_present;
            in_byte_reg    <= s_command_byte;
        end
        if (advance_en) begin
            out_motor_reg <= out_motor_next;
            out_led_n_reg <= out_led_n_next;
            out_power_reg <= power_level_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_motor_out   = out_motor_reg;
    assign m_led_drive_n = out_led_n_reg;
    assign m_power_pin   = out_power_reg;

    // Motor enable and power pin always move together
    assert property (@(posedge aclk) disable iff (!aresetn)
        motor_enable_reg == power_level_reg)
        else $error("motor enable and power level disagree");

    // A disabled motor carries no duty
    assert property (@(posedge aclk) disable iff (!aresetn)
        !motor_enable_reg |-> motor_duty_reg == '0)
        else $error("disabled motor has nonzero duty");

    // A driven motor pin needs the power pin
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_motor_out) |-> m_power_pin)
        else $error("motor driven without power");

    // A request that leaves the input register always yields a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance_en |=> out_valid_reg)
        else $error("request dropped between stages");

    // Input side is open whenever the input register is empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input stalled while empty");

endmodule
